// File: sv/ubx_frame_receiver_assert.svh
// Assertion macros for the UBX frame receiver.
`ifndef UBX_FRAME_RECEIVER_ASSERT_SVH
`define UBX_FRAME_RECEIVER_ASSERT_SVH

`ifndef ASSERT_OFF
`define UBXFR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UBXFR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define UBXFR_ASSERT(lbl, prop, msg)
`define UBXFR_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

// File: sv/ubxfr_pkg.sv
`default_nettype none

package ubxfr_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int STATUS_W = 2;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    localparam logic [BYTE_W-1:0] SYNC_FIRST  = 8'hB5;
    localparam logic [BYTE_W-1:0] SYNC_SECOND = 8'h62;
    localparam logic [LEN_W-1:0]  ANY_LENGTH  = 16'hFFFF;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_SUM  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd3;

    localparam logic [1:0] REG_FILTER_CLASS    = 2'd0;
    localparam logic [1:0] REG_FILTER_ID       = 2'd1;
    localparam logic [1:0] REG_EXPECTED_LENGTH = 2'd2;
    localparam logic [1:0] REG_MAX_LENGTH      = 2'd3;

    localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 16'd126;

    typedef struct packed {
        logic [BYTE_W-1:0] filter_class;
        logic [BYTE_W-1:0] filter_id;
        logic [LEN_W-1:0]  expected_length;
        logic [LEN_W-1:0]  max_length;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   payload_byte;
        logic [LEN_W-1:0]    byte_index;
        logic                is_end;
        logic [STATUS_W-1:0] frame_status;
        logic [BYTE_W-1:0]   msg_class;
        logic [BYTE_W-1:0]   msg_id;
        logic [LEN_W-1:0]    payload_length;
        logic                filter_match;
    } result_t;

endpackage

`default_nettype wire

// File: sv/ubxfr_in_if.sv
`default_nettype none

interface ubxfr_in_if import ubxfr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: sv/ubxfr_out_if.sv
`default_nettype none

interface ubxfr_out_if import ubxfr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   payload_byte;
    logic [LEN_W-1:0]    byte_index;
    logic                is_end;
    logic [STATUS_W-1:0] frame_status;
    logic [BYTE_W-1:0]   msg_class;
    logic [BYTE_W-1:0]   msg_id;
    logic [LEN_W-1:0]    payload_length;
    logic                filter_match;

    modport source (output valid, output payload_byte, output byte_index, output is_end,
                    output frame_status, output msg_class, output msg_id,
                    output payload_length, output filter_match, input ready);
    modport sink (input valid, input payload_byte, input byte_index, input is_end,
                  input frame_status, input msg_class, input msg_id,
                  input payload_length, input filter_match, output ready);
endinterface

`default_nettype wire

// File: sv/ubx_frame_receiver.sv
// UBX frame receiver.
// in_ch carries one received serial byte per item (valid/ready). The parser
// hunts for the two sync bytes, reads class, id and a little-endian length,
// then the payload and the two 8-bit Fletcher check bytes.
// out_ch carries at most one item per input byte: each payload byte with its
// index, and one end item per frame with class, id, length, filter match and
// status (ok, bad checksum, too long, length mismatch).
// The APB port sets filter_class, filter_id, expected_length and max_length
// at byte addresses 0, 4, 8 and 12; write only while the block is idle.
// An accepted byte is parsed from the input register, and any result that it
// gives is loaded into the output register, which drives out_ch.valid.
// Throughput: one byte per cycle while no result waits on a full output
// register, set by the single parse stage between the two registers.
// A full output register that is not taken stalls only bytes that produce a
// result; bytes that give no result keep flowing. in_ch.ready drops once the
// input register holds such a stalled byte.
// Reset clears the parser to the sync hunt and loads the register defaults.
`default_nettype none
`include "ubx_frame_receiver_assert.svh"

module ubx_frame_receiver import ubxfr_pkg::*; (
    input  wire logic              clk,
    input  wire logic              rst_n,
    ubxfr_in_if.sink               in_ch,
    ubxfr_out_if.source            out_ch,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    localparam logic [2:0] PH_HUNT1   = 3'd0;
    localparam logic [2:0] PH_HUNT2   = 3'd1;
    localparam logic [2:0] PH_HEADER  = 3'd2;
    localparam logic [2:0] PH_PAYLOAD = 3'd3;
    localparam logic [2:0] PH_CHECK_A = 3'd4;
    localparam logic [2:0] PH_CHECK_B = 3'd5;

    cfg_t cfg_reg;

    logic              s1_valid_reg;
    logic [BYTE_W-1:0] s1_byte_reg;

    logic [2:0]        phase_reg, phase_next;
    logic [1:0]        hcount_reg, hcount_next;
    logic [BYTE_W-1:0] cur_class_reg, cur_class_next;
    logic [BYTE_W-1:0] cur_id_reg, cur_id_next;
    logic [LEN_W-1:0]  cur_length_reg, cur_length_next;
    logic [LEN_W-1:0]  pcount_reg, pcount_next;
    logic [BYTE_W-1:0] sum_a_reg, sum_a_next;
    logic [BYTE_W-1:0] sum_b_reg, sum_b_next;
    logic [BYTE_W-1:0] check_a_reg, check_a_next;

    logic    out_valid_reg;
    result_t out_reg;
    result_t res_next;
    logic    emit;
    logic    s1_adv;
    logic    cfg_wr;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_class    <= '0;
            cfg_reg.filter_id       <= '0;
            cfg_reg.expected_length <= ANY_LENGTH;
            cfg_reg.max_length      <= MAX_LENGTH_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_FILTER_CLASS:    cfg_reg.filter_class    <= pwdata[BYTE_W-1:0];
                REG_FILTER_ID:       cfg_reg.filter_id       <= pwdata[BYTE_W-1:0];
                REG_EXPECTED_LENGTH: cfg_reg.expected_length <= pwdata[LEN_W-1:0];
                REG_MAX_LENGTH:      cfg_reg.max_length      <= pwdata[LEN_W-1:0];
                default:             ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_FILTER_CLASS:    prdata = {{(APB_DW-BYTE_W){1'b0}}, cfg_reg.filter_class};
            REG_FILTER_ID:       prdata = {{(APB_DW-BYTE_W){1'b0}}, cfg_reg.filter_id};
            REG_EXPECTED_LENGTH: prdata = {{(APB_DW-LEN_W){1'b0}}, cfg_reg.expected_length};
            REG_MAX_LENGTH:      prdata = {{(APB_DW-LEN_W){1'b0}}, cfg_reg.max_length};
            default:             prdata = '0;
        endcase
    end

    // parse logic on the registered byte
    always_comb
    begin
        phase_next      = phase_reg;
        hcount_next     = hcount_reg;
        cur_class_next  = cur_class_reg;
        cur_id_next     = cur_id_reg;
        cur_length_next = cur_length_reg;
        pcount_next     = pcount_reg;
        sum_a_next      = sum_a_reg;
        sum_b_next      = sum_b_reg;
        check_a_next    = check_a_reg;
        emit            = 1'b0;
        res_next.payload_byte = '0;
        res_next.byte_index   = '0;
        res_next.is_end       = 1'b0;
        res_next.frame_status = ST_OK;

        case (phase_reg)
            PH_HUNT1:
            begin
                if (s1_byte_reg == SYNC_FIRST)
                    phase_next = PH_HUNT2;
            end
            PH_HUNT2:
            begin
                if (s1_byte_reg == SYNC_SECOND)
                begin
                    phase_next  = PH_HEADER;
                    hcount_next = '0;
                    sum_a_next  = '0;
                    sum_b_next  = '0;
                    pcount_next = '0;
                end
                else
                begin
                    phase_next = PH_HUNT1;
                end
            end
            PH_HEADER:
            begin
                sum_a_next = sum_a_reg + s1_byte_reg;
                sum_b_next = sum_b_reg + sum_a_next;
                case (hcount_reg)
                    2'd0:    cur_class_next  = s1_byte_reg;
                    2'd1:    cur_id_next     = s1_byte_reg;
                    2'd2:    cur_length_next = {{(LEN_W-BYTE_W){1'b0}}, s1_byte_reg};
                    default: cur_length_next = {s1_byte_reg, cur_length_reg[BYTE_W-1:0]};
                endcase
                if (hcount_reg != 2'd3)
                begin
                    hcount_next = hcount_reg + 2'd1;
                end
                else
                begin
                    hcount_next = '0;
                    pcount_next = '0;
                    if (cur_length_next > cfg_reg.max_length)
                    begin
                        phase_next            = PH_HUNT1;
                        emit                  = 1'b1;
                        res_next.is_end       = 1'b1;
                        res_next.frame_status = ST_TOO_LONG;
                    end
                    else if (cur_length_next == '0)
                    begin
                        phase_next = PH_CHECK_A;
                    end
                    else
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                sum_a_next            = sum_a_reg + s1_byte_reg;
                sum_b_next            = sum_b_reg + sum_a_next;
                emit                  = 1'b1;
                res_next.payload_byte = s1_byte_reg;
                res_next.byte_index   = pcount_reg;
                pcount_next           = pcount_reg + 16'd1;
                if (pcount_next >= cur_length_reg)
                    phase_next = PH_CHECK_A;
            end
            PH_CHECK_A:
            begin
                check_a_next = s1_byte_reg;
                phase_next   = PH_CHECK_B;
            end
            PH_CHECK_B:
            begin
                emit                = 1'b1;
                phase_next          = PH_HUNT1;
                res_next.is_end     = 1'b1;
                res_next.byte_index = pcount_reg;
                if (check_a_reg != sum_a_reg || s1_byte_reg != sum_b_reg)
                    res_next.frame_status = ST_BAD_SUM;
                else if (cur_class_reg == cfg_reg.filter_class
                         && cur_id_reg == cfg_reg.filter_id
                         && cfg_reg.expected_length != ANY_LENGTH
                         && cur_length_reg != cfg_reg.expected_length)
                    res_next.frame_status = ST_MISMATCH;
            end
            default:
            begin
                phase_next = PH_HUNT1;
            end
        endcase

        res_next.msg_class      = cur_class_next;
        res_next.msg_id         = cur_id_next;
        res_next.payload_length = cur_length_next;
        res_next.filter_match   = (cur_class_next == cfg_reg.filter_class)
                                  && (cur_id_next == cfg_reg.filter_id);
    end

    // handshake: a byte with no result never waits for the output
    assign s1_adv      = s1_valid_reg && (!emit || !out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ch.ready)
            s1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
            s1_byte_reg <= in_ch.rx_byte;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT1;
            hcount_reg     <= '0;
            cur_class_reg  <= '0;
            cur_id_reg     <= '0;
            cur_length_reg <= '0;
            pcount_reg     <= '0;
            sum_a_reg      <= '0;
            sum_b_reg      <= '0;
            check_a_reg    <= '0;
        end
        else if (s1_adv)
        begin
            phase_reg      <= phase_next;
            hcount_reg     <= hcount_next;
            cur_class_reg  <= cur_class_next;
            cur_id_reg     <= cur_id_next;
            cur_length_reg <= cur_length_next;
            pcount_reg     <= pcount_next;
            sum_a_reg      <= sum_a_next;
            sum_b_reg      <= sum_b_next;
            check_a_reg    <= check_a_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv && emit)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && emit)
            out_reg <= res_next;
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.payload_byte   = out_reg.payload_byte;
    assign out_ch.byte_index     = out_reg.byte_index;
    assign out_ch.is_end         = out_reg.is_end;
    assign out_ch.frame_status   = out_reg.frame_status;
    assign out_ch.msg_class      = out_reg.msg_class;
    assign out_ch.msg_id         = out_reg.msg_id;
    assign out_ch.payload_length = out_reg.payload_length;
    assign out_ch.filter_match   = out_reg.filter_match;

    `UBXFR_ASSERT_IMP(a_hcount_in_header, hcount_reg != 2'd0, phase_reg == PH_HEADER,
        "header count set outside header phase")
    `UBXFR_ASSERT_IMP(a_pcount_bound, phase_reg == PH_PAYLOAD, pcount_reg < cur_length_reg,
        "payload count reached length inside payload phase")
    `UBXFR_ASSERT_IMP(a_data_status_ok, out_valid_reg && !out_reg.is_end,
        out_reg.frame_status == ST_OK, "payload item carries a frame status")
    `UBXFR_ASSERT(a_stall_holds_byte,
        (s1_valid_reg && !s1_adv) |=> (s1_valid_reg && $stable(s1_byte_reg)),
        "stalled input byte lost")
    `UBXFR_ASSERT_IMP(a_no_overwrite, s1_adv && emit && out_valid_reg, out_ch.ready,
        "result register overwritten before it was taken")

endmodule

`default_nettype wire

// File: test/ubx_frame_receiver_test.sv
`timescale 1ns / 100ps

module ubx_frame_receiver_test;
    import ubxfr_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 6;

    typedef enum logic [2:0] {
        SEEK_SYNC1,
        SEEK_SYNC2,
        IN_HEADER,
        IN_PAYLOAD,
        IN_CK_A,
        IN_CK_B
    } parse_phase_t;

    typedef enum {
        FAULT_NONE,
        FAULT_CK_A,
        FAULT_CK_B,
        FAULT_NO_TAIL
    } frame_fault_t;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    ubxfr_in_if byte_ch ();
    ubxfr_out_if result_ch ();

    ubx_frame_receiver dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (byte_ch),
        .out_ch  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shadow of the register file and of the parser
    cfg_t         shadow_cfg;
    parse_phase_t phase;
    logic [1:0]   hdr_count;
    logic [7:0]   frame_class;
    logic [7:0]   frame_id;
    logic [15:0]  frame_len;
    logic [15:0]  body_count;
    logic [7:0]   sum_a;
    logic [7:0]   sum_b;
    logic [7:0]   rx_ck_a;

    result_t     predicted_outputs[$];
    logic [7:0]  frame_body[$];
    int          error_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned idle_cycles = 0;
    bit          tx_eager = 1'b0;
    bit          rx_eager = 1'b0;
    bit          hold_results = 1'b0;

    function automatic logic frame_matches();
        return frame_class == shadow_cfg.filter_class && frame_id == shadow_cfg.filter_id;
    endfunction

    function automatic void queue_result(input logic [7:0] data, input logic [15:0] index,
                                         input logic last, input logic [1:0] status);
        result_t r;
        r.payload_byte   = data;
        r.byte_index     = index;
        r.is_end         = last;
        r.frame_status   = status;
        r.msg_class      = frame_class;
        r.msg_id         = frame_id;
        r.payload_length = frame_len;
        r.filter_match   = frame_matches();
        predicted_outputs.push_back(r);
    endfunction

    function automatic void reset_parser();
        shadow_cfg.filter_class    = 8'h00;
        shadow_cfg.filter_id       = 8'h00;
        shadow_cfg.expected_length = ANY_LENGTH;
        shadow_cfg.max_length      = MAX_LENGTH_RESET;
        phase      = SEEK_SYNC1;
        hdr_count  = 2'd0;
        frame_class = 8'h00;
        frame_id   = 8'h00;
        frame_len  = 16'h0000;
        body_count = 16'h0000;
        sum_a      = 8'h00;
        sum_b      = 8'h00;
        rx_ck_a    = 8'h00;
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        logic [1:0] status;
        case (phase)
            SEEK_SYNC1:
            begin
                if (b == SYNC_FIRST)
                    phase = SEEK_SYNC2;
            end
            SEEK_SYNC2:
            begin
                if (b == SYNC_SECOND)
                begin
                    phase      = IN_HEADER;
                    hdr_count  = 2'd0;
                    sum_a      = 8'h00;
                    sum_b      = 8'h00;
                    body_count = 16'h0000;
                end
                else
                    phase = SEEK_SYNC1;
            end
            IN_HEADER:
            begin
                sum_a = sum_a + b;
                sum_b = sum_b + sum_a;
                case (hdr_count)
                    2'd0: frame_class = b;
                    2'd1: frame_id = b;
                    2'd2: frame_len = {8'h00, b};
                    default: frame_len[15:8] = b;
                endcase
                if (hdr_count != 2'd3)
                    hdr_count = hdr_count + 2'd1;
                else
                begin
                    hdr_count  = 2'd0;
                    body_count = 16'h0000;
                    if (frame_len > shadow_cfg.max_length)
                    begin
                        phase = SEEK_SYNC1;
                        queue_result(8'h00, 16'h0000, 1'b1, ST_TOO_LONG);
                    end
                    else
                        phase = (frame_len == 16'h0000) ? IN_CK_A : IN_PAYLOAD;
                end
            end
            IN_PAYLOAD:
            begin
                sum_a = sum_a + b;
                sum_b = sum_b + sum_a;
                queue_result(b, body_count, 1'b0, ST_OK);
                body_count = body_count + 16'h0001;
                if (body_count >= frame_len)
                    phase = IN_CK_A;
            end
            IN_CK_A:
            begin
                rx_ck_a = b;
                phase   = IN_CK_B;
            end
            IN_CK_B:
            begin
                status = ST_OK;
                if (rx_ck_a != sum_a || b != sum_b)
                    status = ST_BAD_SUM;
                else if (frame_matches() && shadow_cfg.expected_length != ANY_LENGTH &&
                         frame_len != shadow_cfg.expected_length)
                    status = ST_MISMATCH;
                phase = SEEK_SYNC1;
                queue_result(8'h00, body_count, 1'b1, status);
            end
            default: phase = SEEK_SYNC1;
        endcase
    endfunction

    function automatic void compare_field(input string field, input logic [15:0] want,
                                          input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (predicted_outputs.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual byte %0h index %0h end %0b",
                         $time, result_ch.payload_byte, result_ch.byte_index, result_ch.is_end);
                error_count++;
            end
            else
            begin
                want = predicted_outputs.pop_front();
                compare_field("payload_byte", want.payload_byte, result_ch.payload_byte);
                compare_field("byte_index", want.byte_index, result_ch.byte_index);
                compare_field("is_end", want.is_end, result_ch.is_end);
                compare_field("frame_status", want.frame_status, result_ch.frame_status);
                compare_field("msg_class", want.msg_class, result_ch.msg_class);
                compare_field("msg_id", want.msg_id, result_ch.msg_id);
                compare_field("payload_length", want.payload_length, result_ch.payload_length);
                compare_field("filter_match", want.filter_match, result_ch.filter_match);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || psel || (byte_ch.valid && byte_ch.ready) ||
            (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[ubx_frame_receiver] ERROR");
                $finish;
            end
        end
    end

    // result side: random stalls, eager stretches, and one long hold-off on request
    initial
    begin : result_sink
        int unsigned pause;
        result_ch.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_results)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_results = 1'b0;
            end
            if ($urandom_range(0, 31) == 0)
                rx_eager = !rx_eager;
            pause = rx_eager ? 0 : $urandom_range(0, 19);
            if (pause > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_ch.valid && result_ch.ready));
        end
    end

    task automatic send_byte(input logic [7:0] value);
        int unsigned gap;
        gap = tx_eager ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= value;
        do
            @(posedge clk);
        while (!(byte_ch.valid && byte_ch.ready));
        deframe_byte(value);
        bytes_sent++;
    endtask

    // wait until the block has nothing left in flight
    task automatic drain();
        byte_ch.valid <= 1'b0;
        while (predicted_outputs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        logic [31:0] kept;
        drain();
        case (index)
            REG_FILTER_CLASS:
            begin
                shadow_cfg.filter_class = value[7:0];
                kept = {24'h0, value[7:0]};
            end
            REG_FILTER_ID:
            begin
                shadow_cfg.filter_id = value[7:0];
                kept = {24'h0, value[7:0]};
            end
            REG_EXPECTED_LENGTH:
            begin
                shadow_cfg.expected_length = value[15:0];
                kept = {16'h0, value[15:0]};
            end
            default:
            begin
                shadow_cfg.max_length = value[15:0];
                kept = {16'h0, value[15:0]};
            end
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== kept)
        begin
            $display("%0t: register %0d readback, expected %0h, actual %0h",
                     $time, index, kept, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // sync, header, frame_body, then the check bytes unless the fault drops them
    task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                              input logic [15:0] len_field, input frame_fault_t fault);
        logic [7:0] hdr[4];
        logic [7:0] ck_a;
        logic [7:0] ck_b;
        ck_a = 8'h00;
        ck_b = 8'h00;
        hdr[0] = cls;
        hdr[1] = id;
        hdr[2] = len_field[7:0];
        hdr[3] = len_field[15:8];
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        foreach (hdr[i])
        begin
            ck_a = ck_a + hdr[i];
            ck_b = ck_b + ck_a;
            send_byte(hdr[i]);
        end
        foreach (frame_body[i])
        begin
            ck_a = ck_a + frame_body[i];
            ck_b = ck_b + ck_a;
            send_byte(frame_body[i]);
        end
        if (fault != FAULT_NO_TAIL)
        begin
            if (fault == FAULT_CK_A)
                ck_a = ck_a ^ 8'($urandom_range(1, 255));
            if (fault == FAULT_CK_B)
                ck_b = ck_b ^ 8'($urandom_range(1, 255));
            send_byte(ck_a);
            send_byte(ck_b);
        end
    endtask

    task automatic send_random_frame();
        int unsigned pick;
        int unsigned cap;
        int unsigned body_len;
        logic [7:0]  cls;
        logic [7:0]  id;
        logic [15:0] len;
        frame_fault_t fault;
        pick = $urandom_range(0, 99);
        tx_eager = ($urandom_range(0, 4) == 0);
        cls = ($urandom_range(0, 9) < 4) ? shadow_cfg.filter_class : 8'($urandom);
        id = (cls == shadow_cfg.filter_class && $urandom_range(0, 3) != 0) ?
             shadow_cfg.filter_id : 8'($urandom);
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4))
                send_byte(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom));
        fault = FAULT_NONE;
        if (pick < 6)
        begin
            if (shadow_cfg.max_length >= 16'hFFF0 || $urandom_range(0, 2) == 0)
                len = 16'hFFFF;
            else
                len = shadow_cfg.max_length + 16'($urandom_range(1, 4));
            fault = FAULT_NO_TAIL;
            body_len = 0;
        end
        else
        begin
            cap = (shadow_cfg.max_length < 24) ? shadow_cfg.max_length : 24;
            if ($urandom_range(0, 11) == 0)
                cap = (shadow_cfg.max_length < 300) ? shadow_cfg.max_length : 300;
            len = 16'($urandom_range(0, cap));
            if (shadow_cfg.expected_length <= shadow_cfg.max_length && $urandom_range(0, 3) == 0)
                len = shadow_cfg.expected_length;
            body_len = len;
            if (pick < 12)
                fault = FAULT_CK_A;
            else if (pick < 18)
                fault = FAULT_CK_B;
            else if (pick < 22)
            begin
                fault = FAULT_NO_TAIL;
                body_len = $urandom_range(0, len);
            end
        end
        frame_body.delete();
        repeat (body_len) frame_body.push_back(8'($urandom));
        send_frame(cls, id, len, fault);
    endtask

    task automatic run_random(input int unsigned budget);
        int unsigned start;
        start = bytes_sent;
        while (bytes_sent - start < budget)
            send_random_frame();
        tx_eager = 1'b0;
    endtask

    task automatic test_idle_and_sync();
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(SYNC_SECOND);
        send_byte(SYNC_FIRST);
        send_byte(8'h00);
        // repeated first sync byte is consumed, so the following 0x62 is ignored
        send_byte(SYNC_FIRST);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(8'hFF);
    endtask

    task automatic test_empty_frame();
        frame_body.delete();
        send_frame(8'hFF, 8'h00, 16'd0, FAULT_NONE);
        send_frame(8'h00, 8'h00, 16'd0, FAULT_NONE);
    endtask

    task automatic test_payload_extremes();
        frame_body = '{8'h00, 8'hFF};
        send_frame(8'h00, 8'hFF, 16'd2, FAULT_NONE);
    endtask

    task automatic test_bad_checksum();
        frame_body.delete();
        send_frame(8'h00, 8'h00, 16'd0, FAULT_CK_A);
        frame_body = '{8'hA5};
        send_frame(8'h12, 8'h34, 16'd1, FAULT_CK_B);
    endtask

    task automatic test_too_long();
        frame_body.delete();
        send_frame(8'h01, 8'h07, 16'hFFFF, FAULT_NO_TAIL);
        send_frame(8'h01, 8'h07, MAX_LENGTH_RESET + 16'd1, FAULT_NO_TAIL);
        frame_body = '{8'h5A};
        send_frame(8'h00, 8'h00, 16'd1, FAULT_NONE);
    endtask

    task automatic test_default_traffic();
        run_random(350);
    endtask

    task automatic test_length_mismatch();
        // upper bits of the bus are dropped by the register widths
        write_reg(REG_FILTER_CLASS, 32'h5A5A_A5FF);
        write_reg(REG_FILTER_ID, 32'hFFFF_FF00);
        write_reg(REG_EXPECTED_LENGTH, 32'h1234_0005);
        write_reg(REG_MAX_LENGTH, 32'hFFFF_0000);
        frame_body.delete();
        send_frame(8'hFF, 8'h00, 16'd0, FAULT_NONE);
        send_frame(8'hFF, 8'h01, 16'd0, FAULT_NONE);
        send_frame(8'hFF, 8'h00, 16'd0, FAULT_CK_B);
        send_frame(8'hFF, 8'h00, 16'd5, FAULT_NO_TAIL);
        run_random(150);
    endtask

    task automatic test_zero_expected_length();
        write_reg(REG_FILTER_CLASS, $urandom);
        write_reg(REG_FILTER_ID, $urandom);
        write_reg(REG_EXPECTED_LENGTH, 32'd0);
        write_reg(REG_MAX_LENGTH, 32'd40);
        run_random(300);
    endtask

    task automatic test_wide_limits();
        write_reg(REG_FILTER_CLASS, 32'h01);
        write_reg(REG_FILTER_ID, 32'h07);
        write_reg(REG_EXPECTED_LENGTH, ANY_LENGTH);
        write_reg(REG_MAX_LENGTH, 32'd65534);
        frame_body.delete();
        repeat (300) frame_body.push_back(8'($urandom));
        send_frame(8'h01, 8'h07, 16'd300, FAULT_NONE);
        frame_body.delete();
        send_frame(8'h01, 8'h07, 16'hFFFF, FAULT_NO_TAIL);
        run_random(250);
    endtask

    task automatic test_output_backpressure();
        drain();
        tx_eager = 1'b1;
        hold_results = 1'b1;
        repeat (6)
        begin
            frame_body.delete();
            repeat (10) frame_body.push_back(8'($urandom));
            send_frame(8'h01, 8'h07, 16'd10, FAULT_NONE);
        end
        tx_eager = 1'b0;
    endtask

    task automatic test_restored_limits();
        write_reg(REG_FILTER_CLASS, $urandom);
        write_reg(REG_FILTER_ID, $urandom);
        write_reg(REG_EXPECTED_LENGTH, $urandom_range(1, 126));
        write_reg(REG_MAX_LENGTH, MAX_LENGTH_RESET);
        run_random(250);
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        byte_ch.valid   <= 1'b0;
        byte_ch.rx_byte <= 8'h00;
        reset_parser();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_and_sync();
        test_empty_frame();
        test_payload_extremes();
        test_bad_checksum();
        test_too_long();
        test_default_traffic();
        test_length_mismatch();
        test_zero_expected_length();
        test_wide_limits();
        test_output_backpressure();
        test_restored_limits();
        drain();
        if (error_count == 0)
            $display("[ubx_frame_receiver] OK");
        else
            $display("[ubx_frame_receiver] ERROR");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/ubxfr_pkg.sv
sv/ubxfr_in_if.sv
sv/ubxfr_out_if.sv
sv/ubx_frame_receiver.sv
test/ubx_frame_receiver_test.sv
